[hw/rtl/drb_pkg.sv]
// shared types, codes and helpers for the discovery retry backoff controller
`timescale 1ns / 1ps

package drb_pkg;

   localparam int TIME_BITS = 32;

   localparam logic [31:0] BASE_BACKOFF_RESET  = 32'd1000;
   localparam logic [31:0] MAX_BACKOFF_RESET   = 32'd30000;
   localparam logic [7:0]  MAX_ATTEMPTS_RESET  = 8'd5;
   localparam logic [15:0] DEFAULT_PORT_RESET  = 16'd8080;
   localparam logic [7:0]  ATTEMPTS_MAX        = 8'd255;

   typedef enum logic [2:0] {
      ST_IDLE      = 3'd0,
      ST_BROWSING  = 3'd1,
      ST_RESOLVING = 3'd2,
      ST_BACKOFF   = 3'd3,
      ST_FOUND     = 3'd4,
      ST_FAILED    = 3'd5
   } state_type;

   typedef enum logic [1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_BEGIN = 2'd1,
      FUNC_RESET = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      CSR_BASE_BACKOFF = 2'd0,
      CSR_MAX_BACKOFF  = 2'd1,
      CSR_MAX_ATTEMPTS = 2'd2,
      CSR_DEFAULT_PORT = 2'd3
   } csr_index_type;

   typedef logic [TIME_BITS-1:0] time_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] now_ms;
      logic        link_up;
      logic        responder_ok;
      logic [31:0] answer_ip;
      logic [15:0] answer_port;
   } req_type;

   typedef struct packed {
      logic [2:0]  run_state;
      logic [7:0]  attempt_count;
      logic [31:0] endpoint_ip;
      logic [15:0] endpoint_port;
      logic        port_from_service;
      logic [31:0] next_try_ms;
   } rsp_type;

   typedef struct packed {
      logic [31:0] base_backoff_ms;
      logic [31:0] max_backoff_ms;
      logic [7:0]  max_attempts;
      logic [15:0] default_port;
   } cfg_type;

   typedef struct packed {
      state_type   state;
      logic [7:0]  attempts;
      time_type    retry_time;
      logic [31:0] found_ip;
      logic [15:0] found_port;
      logic        from_service;
   } ctx_type;

   // min(base << n, cap) without wrap
   function automatic logic [31:0] backoff_delay(input logic [31:0] base,
                                                 input logic [31:0] cap,
                                                 input logic [7:0]  n);
      logic [63:0] shifted;
      logic [31:0] result;
      shifted = {32'd0, base} << n[4:0];
      if (base == 32'd0) begin
         result = 32'd0;
      end else if (n[7:5] != 3'd0) begin
         result = cap;
      end else if (shifted > {32'd0, cap}) begin
         result = cap;
      end else begin
         result = shifted[31:0];
      end
      return result;
   endfunction

endpackage

[hw/rtl/drb_step.sv]
// next run context for one event
`timescale 1ns / 1ps

module drb_step (
   input  drb_pkg::ctx_type ctx,
   input  drb_pkg::cfg_type cfg,
   input  drb_pkg::req_type req,
   output drb_pkg::ctx_type ctx_next
);

   drb_pkg::time_type now;
   drb_pkg::time_type since_retry;
   drb_pkg::time_type delay;
   logic [7:0]        att_inc;
   logic              give_up;
   logic              is_tick;
   logic              in_query;
   logic              query_live;
   logic              ev_fail;
   logic              ev_take_svc;
   logic              ev_take_host;
   logic              ev_to_resolve;
   logic              ev_backoff_done;

   assign now         = drb_pkg::TIME_BITS'(req.now_ms);
   assign since_retry = now - ctx.retry_time;
   assign att_inc     = (ctx.attempts == drb_pkg::ATTEMPTS_MAX) ? ctx.attempts
                                                               : ctx.attempts + 8'd1;
   assign give_up     = (att_inc >= cfg.max_attempts);
   assign delay       = drb_pkg::TIME_BITS'(drb_pkg::backoff_delay(
                           cfg.base_backoff_ms, cfg.max_backoff_ms, att_inc));

   // event decode
   always_comb begin
      is_tick    = (drb_pkg::func_type'(req.func) == drb_pkg::FUNC_TICK);
      in_query   = (ctx.state == drb_pkg::ST_BROWSING) ||
                   (ctx.state == drb_pkg::ST_RESOLVING);
      query_live = is_tick && in_query && req.link_up;
      ev_take_svc   = query_live && req.responder_ok &&
                      (ctx.state == drb_pkg::ST_BROWSING) &&
                      (req.answer_ip != 32'd0) && (req.answer_port != 16'd0);
      ev_to_resolve = query_live && req.responder_ok &&
                      (ctx.state == drb_pkg::ST_BROWSING) && !ev_take_svc;
      ev_take_host  = query_live && req.responder_ok &&
                      (ctx.state == drb_pkg::ST_RESOLVING) &&
                      (req.answer_ip != 32'd0);
      ev_fail       = query_live && (!req.responder_ok ||
                      ((ctx.state == drb_pkg::ST_RESOLVING) &&
                       (req.answer_ip == 32'd0)));
      ev_backoff_done = is_tick && (ctx.state == drb_pkg::ST_BACKOFF) &&
                        !since_retry[drb_pkg::TIME_BITS-1];
   end

   // next state and run data
   always_comb begin
      ctx_next.state = ctx.state;
      unique case (drb_pkg::func_type'(req.func))
         drb_pkg::FUNC_BEGIN: begin
            ctx_next.state = drb_pkg::ST_BROWSING;
         end
         drb_pkg::FUNC_RESET: begin
            ctx_next.state = drb_pkg::ST_IDLE;
         end
         drb_pkg::FUNC_TICK: begin
            priority if (ev_take_svc || ev_take_host) begin
               ctx_next.state = drb_pkg::ST_FOUND;
            end else if (ev_to_resolve) begin
               ctx_next.state = drb_pkg::ST_RESOLVING;
            end else if (ev_fail) begin
               ctx_next.state = give_up ? drb_pkg::ST_FAILED : drb_pkg::ST_BACKOFF;
            end else if (ev_backoff_done) begin
               ctx_next.state = drb_pkg::ST_BROWSING;
            end else begin
               ctx_next.state = ctx.state;
            end
         end
         default: begin
            ctx_next.state = ctx.state;
         end
      endcase

      ctx_next.attempts     = ctx.attempts;
      ctx_next.retry_time   = ctx.retry_time;
      ctx_next.found_ip     = ctx.found_ip;
      ctx_next.found_port   = ctx.found_port;
      ctx_next.from_service = ctx.from_service;
      unique case (drb_pkg::func_type'(req.func))
         drb_pkg::FUNC_BEGIN, drb_pkg::FUNC_RESET: begin
            ctx_next.attempts     = 8'd0;
            ctx_next.found_ip     = 32'd0;
            ctx_next.found_port   = 16'd0;
            ctx_next.from_service = 1'b0;
            ctx_next.retry_time   = (drb_pkg::func_type'(req.func) == drb_pkg::FUNC_BEGIN)
                                    ? now : '0;
         end
         drb_pkg::FUNC_TICK: begin
            if (ev_take_svc) begin
               ctx_next.found_ip     = req.answer_ip;
               ctx_next.found_port   = req.answer_port;
               ctx_next.from_service = 1'b1;
            end
            if (ev_take_host) begin
               ctx_next.found_ip     = req.answer_ip;
               ctx_next.found_port   = cfg.default_port;
               ctx_next.from_service = 1'b0;
            end
            if (ev_fail) begin
               ctx_next.attempts = att_inc;
               if (!give_up) begin
                  ctx_next.retry_time = now + delay;
               end
            end
         end
         default: begin
            ctx_next.attempts = ctx.attempts;
         end
      endcase
   end

endmodule

[hw/rtl/discovery_retry_backoff_fsm_top.sv]
// discovery controller with bounded retries and exponential backoff, top level
`timescale 1ns / 1ps

// One event is taken per clock cycle when not stalled, and its result is registered;
// the whole update is a single pass from the event and the stored run context into
// the context and result registers. A new event is taken while the previous result
// still waits, as long as the result register is free or being emptied in the same
// cycle. Configuration writes take effect on the following event.

module discovery_retry_backoff_fsm_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  drb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output drb_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_wdata
);

   drb_pkg::cfg_type cfg_ff;
   drb_pkg::ctx_type ctx_ff;
   drb_pkg::ctx_type ctx_in;
   drb_pkg::rsp_type rsp_data_ff;
   drb_pkg::rsp_type rsp_data_in;
   logic             rsp_valid_ff;
   logic             req_fire;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   drb_step u_step (
      .ctx      (ctx_ff),
      .cfg      (cfg_ff),
      .req      (req_data),
      .ctx_next (ctx_in)
   );

   always_comb begin
      rsp_data_in.run_state         = ctx_in.state;
      rsp_data_in.attempt_count     = ctx_in.attempts;
      rsp_data_in.endpoint_ip       = ctx_in.found_ip;
      rsp_data_in.endpoint_port     = ctx_in.found_port;
      rsp_data_in.port_from_service = ctx_in.from_service;
      rsp_data_in.next_try_ms       = 32'(ctx_in.retry_time);
   end

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_backoff_ms <= drb_pkg::BASE_BACKOFF_RESET;
         cfg_ff.max_backoff_ms  <= drb_pkg::MAX_BACKOFF_RESET;
         cfg_ff.max_attempts    <= drb_pkg::MAX_ATTEMPTS_RESET;
         cfg_ff.default_port    <= drb_pkg::DEFAULT_PORT_RESET;
      end else if (csr_we) begin
         unique case (drb_pkg::csr_index_type'(csr_index))
            drb_pkg::CSR_BASE_BACKOFF: cfg_ff.base_backoff_ms <= csr_wdata;
            drb_pkg::CSR_MAX_BACKOFF:  cfg_ff.max_backoff_ms  <= csr_wdata;
            drb_pkg::CSR_MAX_ATTEMPTS: cfg_ff.max_attempts    <= csr_wdata[7:0];
            drb_pkg::CSR_DEFAULT_PORT: cfg_ff.default_port    <= csr_wdata[15:0];
            default:                   cfg_ff.default_port    <= cfg_ff.default_port;
         endcase
      end
   end

   // run context
   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff.state        <= drb_pkg::ST_IDLE;
         ctx_ff.attempts     <= 8'd0;
         ctx_ff.retry_time   <= '0;
         ctx_ff.found_ip     <= 32'd0;
         ctx_ff.found_port   <= 16'd0;
         ctx_ff.from_service <= 1'b0;
      end else if (req_fire) begin
         ctx_ff <= ctx_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // a found run always holds a real address
   a_found_has_ip: assert property (@(posedge clock) disable iff (reset)
      ctx_ff.state == drb_pkg::ST_FOUND |-> ctx_ff.found_ip != 32'd0)
      else $error("found state without endpoint address");

   // the endpoint is only held while found
   a_endpoint_clear: assert property (@(posedge clock) disable iff (reset)
      ctx_ff.state != drb_pkg::ST_FOUND |->
         ctx_ff.found_ip == 32'd0 && ctx_ff.found_port == 16'd0 && !ctx_ff.from_service)
      else $error("endpoint held outside found state");

   // attempts only drop on begin or reset
   a_attempts_monotonic: assert property (@(posedge clock) disable iff (reset)
      !(req_fire && (req_data.func == drb_pkg::FUNC_BEGIN ||
                     req_data.func == drb_pkg::FUNC_RESET))
      |=> ctx_ff.attempts >= $past(ctx_ff.attempts))
      else $error("attempt count dropped on a tick");

   // every transfer in yields a pending result matching the context
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff && rsp_data_ff.run_state == ctx_ff.state &&
                   rsp_data_ff.attempt_count == ctx_ff.attempts)
      else $error("result does not match run context");

endmodule
